/* hdl/rx_frame_pad_and_address_match_unit_defines.svh */
// Assertion macros for the receive frame pad and address match unit.
// Used by the top level only; no other dependencies.
`ifndef RX_FRAME_PAD_AND_ADDRESS_MATCH_UNIT_DEFINES_SVH
`define RX_FRAME_PAD_AND_ADDRESS_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RFPAM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFPAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rfpam_pkg.sv */
// Shared constants, types and helpers for the receive frame pad and address match unit.
// No dependencies.
`timescale 1ns / 1ps

package rfpam_pkg;

    localparam int MAX_FRAME   = 4096;
    localparam int MIN_FRAME   = 60;
    localparam int MAC_BYTES   = 6;
    localparam int CNT_W       = $clog2(MAX_FRAME + 4);
    localparam int LEN_W       = 13;
    localparam int WORD_W      = 16;
    localparam int MAC_W       = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BCAST_BYTE = 8'hff;

    localparam int ST_OK_BIT      = 0;
    localparam int ST_BCAST_BIT   = 13;
    localparam int ST_STATION_BIT = 14;

    // Configuration register indexes
    localparam logic REG_STATION_MAC = 1'b0;
    localparam logic REG_RX_ENABLED  = 1'b1;

    // One queued command: an optional data byte, and frame close info on the last one
    typedef struct packed {
        logic             has_data;
        logic [7:0]       data;
        logic             frame_end;
        logic             bcast;
        logic             station;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] padded_len;
    } rfpam_cmd_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_STATUS
    } rfpam_phase_t;

    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                            input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = mac[7:0];
            3'd1:    b = mac[15:8];
            3'd2:    b = mac[23:16];
            3'd3:    b = mac[31:24];
            3'd4:    b = mac[39:32];
            3'd5:    b = mac[47:40];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hdl/rfpam_front.sv */
// Front end: accepts bytes, holds configuration, tracks count and address match,
// and builds queue commands. Depends on rfpam_pkg.
`timescale 1ns / 1ps

module rfpam_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [rfpam_pkg::MAC_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_frame_end,
    input  logic                          q_full,
    output logic                          q_push,
    output rfpam_pkg::rfpam_cmd_t         q_cmd
);

    logic [rfpam_pkg::MAC_W-1:0] mac_reg;
    logic                        rx_en_reg;
    logic [rfpam_pkg::CNT_W-1:0] count_reg, count_next;
    logic                        bcast_reg, bcast_next;
    logic                        station_reg, station_next;

    logic                        accept;
    logic                        in_range;
    logic                        addr_byte;
    logic [7:0]                  mac_cur;
    logic                        bcast_cur, station_cur;
    logic                        bcast_fin, station_fin;
    logic [rfpam_pkg::CNT_W-1:0] cnt_new;
    logic [rfpam_pkg::CNT_W-1:0] len_min, len_sum;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_range  = count_reg < rfpam_pkg::CNT_W'(rfpam_pkg::MAX_FRAME);
        addr_byte = count_reg < rfpam_pkg::CNT_W'(rfpam_pkg::MAC_BYTES);
        mac_cur   = rfpam_pkg::mac_byte(mac_reg, count_reg[2:0]);

        bcast_cur   = bcast_reg &&
                      !(in_range && addr_byte && (s_rx_byte != rfpam_pkg::BCAST_BYTE));
        station_cur = station_reg &&
                      !(in_range && addr_byte && (s_rx_byte != mac_cur));
        cnt_new     = count_reg + rfpam_pkg::CNT_W'(in_range);

        // Missing address bytes of a short frame count as zero
        bcast_fin   = bcast_cur && (cnt_new >= rfpam_pkg::CNT_W'(rfpam_pkg::MAC_BYTES));
        station_fin = station_cur;
        for (int i = 0; i < rfpam_pkg::MAC_BYTES; i++) begin
            if ((rfpam_pkg::CNT_W'(i) >= cnt_new) &&
                (rfpam_pkg::mac_byte(mac_reg, 3'(i)) != 8'h00)) begin
                station_fin = 1'b0;
            end
        end

        len_min = (cnt_new < rfpam_pkg::CNT_W'(rfpam_pkg::MIN_FRAME)) ?
                  rfpam_pkg::CNT_W'(rfpam_pkg::MIN_FRAME) : cnt_new;
        len_sum = len_min + rfpam_pkg::CNT_W'(3);

        q_cmd.has_data   = in_range;
        q_cmd.data       = s_rx_byte;
        q_cmd.frame_end  = s_frame_end;
        q_cmd.bcast      = bcast_fin;
        q_cmd.station    = station_fin;
        q_cmd.count      = cnt_new;
        q_cmd.padded_len = {len_sum[rfpam_pkg::CNT_W-1:2], 2'b00};

        q_push = accept && rx_en_reg && (in_range || s_frame_end);

        count_next   = count_reg;
        bcast_next   = bcast_reg;
        station_next = station_reg;
        if (accept) begin
            if (!rx_en_reg || s_frame_end) begin
                // drop or close the frame: back to the idle frame state
                count_next   = '0;
                bcast_next   = 1'b1;
                station_next = 1'b1;
            end else begin
                count_next   = cnt_new;
                bcast_next   = bcast_cur;
                station_next = station_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg     <= '0;
            rx_en_reg   <= 1'b0;
            count_reg   <= '0;
            bcast_reg   <= 1'b1;
            station_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    rfpam_pkg::REG_STATION_MAC: mac_reg   <= cfg_wr_data;
                    rfpam_pkg::REG_RX_ENABLED:  rx_en_reg <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            count_reg   <= count_next;
            bcast_reg   <= bcast_next;
            station_reg <= station_next;
        end
    end

endmodule

/* hdl/rfpam_queue.sv */
// Short command queue between front and back end.
// Depends on rfpam_pkg.
`timescale 1ns / 1ps

module rfpam_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rfpam_pkg::rfpam_cmd_t push_cmd,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output rfpam_pkg::rfpam_cmd_t head_cmd
);

    rfpam_pkg::rfpam_cmd_t mem [rfpam_pkg::QUEUE_DEPTH];

    logic [rfpam_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rfpam_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rfpam_pkg::QCNT_W-1:0] fill_reg, fill_next;
    logic                         do_pop;

    assign full       = fill_reg == rfpam_pkg::QCNT_W'(rfpam_pkg::QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rfpam_pkg::QPTR_W'(rfpam_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + rfpam_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == rfpam_pkg::QPTR_W'(rfpam_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + rfpam_pkg::QPTR_W'(1);
        end
        fill_next = fill_reg + rfpam_pkg::QCNT_W'(push) - rfpam_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* hdl/rfpam_back.sv */
// Back end: plays out data bytes, zero padding and the closing status result
// into an output register. Depends on rfpam_pkg.
`timescale 1ns / 1ps

module rfpam_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  rfpam_pkg::rfpam_cmd_t         head_cmd,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_data_byte,
    output logic                          m_is_status,
    output logic [rfpam_pkg::WORD_W-1:0]  m_status_word,
    output logic [rfpam_pkg::LEN_W-1:0]   m_frame_length,
    output logic                          m_last
);

    rfpam_pkg::rfpam_phase_t     phase_reg, phase_next;
    logic [rfpam_pkg::CNT_W-1:0] pad_cnt_reg, pad_cnt_next;
    logic [rfpam_pkg::CNT_W-1:0] pad_inc;

    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   data_reg, data_next;
    logic                         status_reg, status_next;
    logic [rfpam_pkg::WORD_W-1:0] word_reg, word_next;
    logic [rfpam_pkg::LEN_W-1:0]  len_reg, len_next;

    logic                         can_load;
    logic                         load;
    logic [rfpam_pkg::WORD_W-1:0] word_build;

    assign can_load = !m_valid_reg || m_ready;
    assign pad_inc  = pad_cnt_reg + rfpam_pkg::CNT_W'(1);

    always_comb begin
        word_build = '0;
        word_build[rfpam_pkg::ST_OK_BIT]      = 1'b1;
        word_build[rfpam_pkg::ST_BCAST_BIT]   = head_cmd.bcast;
        word_build[rfpam_pkg::ST_STATION_BIT] = head_cmd.station;
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            rfpam_pkg::PH_DATA: begin
                if (head_valid && head_cmd.frame_end &&
                    (!head_cmd.has_data || can_load)) begin
                    phase_next = (head_cmd.count < head_cmd.padded_len) ?
                                 rfpam_pkg::PH_PAD : rfpam_pkg::PH_STATUS;
                end
            end
            rfpam_pkg::PH_PAD: begin
                if (can_load && (pad_inc == head_cmd.padded_len)) begin
                    phase_next = rfpam_pkg::PH_STATUS;
                end
            end
            rfpam_pkg::PH_STATUS: begin
                if (can_load) begin
                    phase_next = rfpam_pkg::PH_DATA;
                end
            end
            default: phase_next = rfpam_pkg::PH_DATA;
        endcase
    end

    // Output register loads, queue pops and pad counter
    always_comb begin
        load         = 1'b0;
        pop          = 1'b0;
        pad_cnt_next = pad_cnt_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        case (phase_reg)
            rfpam_pkg::PH_DATA: begin
                if (head_valid) begin
                    pad_cnt_next = head_cmd.count;
                    if (head_cmd.has_data && can_load) begin
                        load        = 1'b1;
                        data_next   = head_cmd.data;
                        status_next = 1'b0;
                        word_next   = '0;
                        len_next    = '0;
                        pop         = !head_cmd.frame_end;
                    end
                end
            end
            rfpam_pkg::PH_PAD: begin
                if (can_load) begin
                    load         = 1'b1;
                    data_next    = 8'h00;
                    status_next  = 1'b0;
                    word_next    = '0;
                    len_next     = '0;
                    pad_cnt_next = pad_inc;
                end
            end
            rfpam_pkg::PH_STATUS: begin
                if (can_load) begin
                    load        = 1'b1;
                    data_next   = 8'h00;
                    status_next = 1'b1;
                    word_next   = word_build;
                    len_next    = rfpam_pkg::LEN_W'(head_cmd.padded_len);
                    pop         = 1'b1;
                end
            end
            default: ;
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        pad_cnt_reg <= pad_cnt_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        word_reg    <= word_next;
        len_reg     <= len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= rfpam_pkg::PH_DATA;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_byte    = data_reg;
    assign m_is_status    = status_reg;
    assign m_status_word  = word_reg;
    assign m_frame_length = len_reg;
    assign m_last         = status_reg;

endmodule

/* hdl/rx_frame_pad_and_address_match_unit.sv */
// Top level of the receive frame pad and address match unit.
// Depends on rfpam_pkg, rfpam_front, rfpam_queue, rfpam_back and the defines header.
//
//   channel | direction | payload
//   s_      | in        | rx_byte, frame_end
//   m_      | out       | data_byte, is_status, status_word, frame_length, last
//   cfg_    | in        | write only: station_mac (index 0), rx_enabled (index 1)
//
// One input byte per cycle when the two-entry command queue has room.
// At frame end the back end plays out the pad bytes and then the status through the
// output register's single port, so input stalls once the queue fills.
// Synchronous active-low reset; no clearing pass. Either side may stall at will.
`timescale 1ns / 1ps
`include "rx_frame_pad_and_address_match_unit_defines.svh"

module rx_frame_pad_and_address_match_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [rfpam_pkg::MAC_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_data_byte,
    output logic                          m_is_status,
    output logic [rfpam_pkg::WORD_W-1:0]  m_status_word,
    output logic [rfpam_pkg::LEN_W-1:0]   m_frame_length,
    output logic                          m_last
);

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  head_valid;
    rfpam_pkg::rfpam_cmd_t push_cmd;
    rfpam_pkg::rfpam_cmd_t head_cmd;
    logic                  status_out;
    logic                  status_taken;
    logic                  status_fields_ok;

    rfpam_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    rfpam_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rfpam_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_is_status    (m_is_status),
        .m_status_word  (m_status_word),
        .m_frame_length (m_frame_length),
        .m_last         (m_last)
    );

    assign status_out       = m_valid && m_is_status;
    assign status_taken     = m_valid && m_ready && m_is_status;
    assign status_fields_ok = (m_frame_length[1:0] == 2'b00) &&
                              (m_frame_length >= rfpam_pkg::LEN_W'(rfpam_pkg::MIN_FRAME)) &&
                              m_status_word[rfpam_pkg::ST_OK_BIT];

    `RFPAM_ASSERT_NOW(a_no_push_full, aclk, aresetn, q_push, !q_full, "queue push while full")
    `RFPAM_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, q_pop, head_valid, "queue pop while empty")
    `RFPAM_ASSERT_NOW(a_status_len, aclk, aresetn, status_out, status_fields_ok, "bad status")
    `RFPAM_ASSERT_NEXT(a_status_drains, aclk, aresetn, status_taken, !status_out, "status repeated")

endmodule

/* sim/testbench.sv */
// Self-checking bench for rx_frame_pad_and_address_match_unit: a directed row list, boundary
// frame sizes, then random frames. Depends on rfpam_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_PAUSE   = 16;
    localparam int RANDOM_ITEMS  = 150;
    localparam int STEADY_FROM   = 40;
    localparam int STEADY_TO     = 100;
    localparam int MISMATCH_SHOW = 10;

    localparam logic [rfpam_pkg::WORD_W-1:0] HDR_OK =
        rfpam_pkg::WORD_W'(1) << rfpam_pkg::ST_OK_BIT;
    localparam logic [rfpam_pkg::WORD_W-1:0] HDR_BCAST =
        rfpam_pkg::WORD_W'(1) << rfpam_pkg::ST_BCAST_BIT;
    localparam logic [rfpam_pkg::WORD_W-1:0] HDR_STATION =
        rfpam_pkg::WORD_W'(1) << rfpam_pkg::ST_STATION_BIT;
    localparam logic [rfpam_pkg::LEN_W-1:0]  PAD_LEN_60 = rfpam_pkg::LEN_W'(60);

    typedef struct packed {
        logic [7:0]                   data_byte;
        logic                         is_status;
        logic [rfpam_pkg::WORD_W-1:0] status_word;
        logic [rfpam_pkg::LEN_W-1:0]  frame_length;
        logic                         last;
    } rx_result_t;

    typedef enum logic [1:0] { ROW_BYTE, ROW_CFG } row_kind_t;
    typedef enum logic [1:0] { DEST_BCAST, DEST_OWN, DEST_NEAR, DEST_ANY } dest_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic                         reg_index;
        logic [rfpam_pkg::MAC_W-1:0]  value;
        logic                         frame_end;
        logic                         pinned;
        logic [rfpam_pkg::WORD_W-1:0] word;
        logic [rfpam_pkg::LEN_W-1:0]  len;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic                         cfg_index   = rfpam_pkg::REG_STATION_MAC;
    logic [rfpam_pkg::MAC_W-1:0]  cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_rx_byte   = '0;
    logic                         s_frame_end = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [7:0]                   m_data_byte;
    logic                         m_is_status;
    logic [rfpam_pkg::WORD_W-1:0] m_status_word;
    logic [rfpam_pkg::LEN_W-1:0]  m_frame_length;
    logic                         m_last;

    // predictor copy of the registers and the frame in progress
    logic [rfpam_pkg::MAC_W-1:0]  station_mac_q = '0;
    logic                         rx_on_q       = 1'b0;
    int unsigned                  frame_bytes   = 0;
    logic                         bcast_hit     = 1'b1;
    logic                         station_hit   = 1'b1;
    rx_result_t                   rx_results_due[$];
    rx_result_t                   pinned_status[$];

    // stimulus-side view of the registers
    logic [rfpam_pkg::MAC_W-1:0]  mac_now    = '0;
    logic                         steady_run = 1'b0;
    stim_row_t                    dir_rows[$];

    int unsigned live_items    = 0;
    int unsigned items_in      = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_closed = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    rx_frame_pad_and_address_match_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_is_status    (m_is_status),
        .m_status_word  (m_status_word),
        .m_frame_length (m_frame_length),
        .m_last         (m_last)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(99) >= 30);
    end

    function automatic void restart_frame();
        frame_bytes = 0;
        bcast_hit   = 1'b1;
        station_hit = 1'b1;
    endfunction

    function automatic void match_address(int unsigned pos, logic [7:0] b);
        if (pos < rfpam_pkg::MAC_BYTES) begin
            if (b != rfpam_pkg::BCAST_BYTE) bcast_hit = 1'b0;
            if (b != station_mac_q[8*pos +: 8]) station_hit = 1'b0;
        end
    endfunction

    // Work out the results that one accepted byte causes.
    function automatic void pad_and_match_step(logic [7:0] b, logic fend);
        rx_result_t  r;
        int unsigned padded;
        if (!rx_on_q) begin
            restart_frame();
            return;
        end
        if (frame_bytes < rfpam_pkg::MAX_FRAME) begin
            match_address(frame_bytes, b);
            r = '0;
            r.data_byte = b;
            rx_results_due.push_back(r);
            frame_bytes++;
            live_items++;
        end
        if (!fend) return;
        // missing address bytes of a short frame compare as zero
        for (int unsigned i = frame_bytes; i < rfpam_pkg::MAC_BYTES; i++) begin
            match_address(i, 8'h00);
        end
        padded = (frame_bytes < rfpam_pkg::MIN_FRAME) ? rfpam_pkg::MIN_FRAME : frame_bytes;
        padded = (padded + 3) & ~32'd3;
        r = '0;
        repeat (padded - frame_bytes) rx_results_due.push_back(r);
        r.is_status    = 1'b1;
        r.last         = 1'b1;
        r.status_word  = HDR_OK | (bcast_hit ? HDR_BCAST : '0) |
                         (station_hit ? HDR_STATION : '0);
        r.frame_length = rfpam_pkg::LEN_W'(padded);
        if (pinned_status.size() != 0) begin
            // directed rows carry the status typed in by hand
            r = pinned_status.pop_front();
        end
        rx_results_due.push_back(r);
        restart_frame();
    endfunction

    always @(posedge aclk) begin
        rx_result_t got;
        rx_result_t want;
        if (!aresetn) begin
            station_mac_q = '0;
            rx_on_q       = 1'b0;
            restart_frame();
            rx_results_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    rfpam_pkg::REG_STATION_MAC: station_mac_q = cfg_wr_data;
                    rfpam_pkg::REG_RX_ENABLED:  rx_on_q = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                items_in++;
                pad_and_match_step(s_rx_byte, s_frame_end);
            end
            if (m_valid && m_ready) begin
                got = {m_data_byte, m_is_status, m_status_word, m_frame_length, m_last};
                results_seen++;
                if (got.is_status) frames_closed++;
                if (rx_results_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MISMATCH_SHOW)
                        $display({"result %0d with nothing expected: ",
                                  "data=%02h st=%0b word=%04h len=%0d last=%0b"},
                                 results_seen, got.data_byte, got.is_status, got.status_word,
                                 got.frame_length, got.last);
                end else begin
                    want = rx_results_due.pop_front();
                    if (got.data_byte !== want.data_byte || got.is_status !== want.is_status ||
                        got.status_word !== want.status_word ||
                        got.frame_length !== want.frame_length || got.last !== want.last) begin
                        error_count++;
                        if (error_count <= MISMATCH_SHOW) begin
                            $display("mismatch at result %0d", results_seen);
                            $display("  want data=%02h st=%0b word=%04h len=%0d last=%0b",
                                     want.data_byte, want.is_status, want.status_word,
                                     want.frame_length, want.last);
                            $display("  got  data=%02h st=%0b word=%04h len=%0d last=%0b",
                                     got.data_byte, got.is_status, got.status_word,
                                     got.frame_length, got.last);
                        end
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fend);
        while (!steady_run && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_rx_byte   <= b;
        s_frame_end <= fend;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Write only once every due result is out and the unit has settled.
    task automatic write_reg(input logic idx, input logic [rfpam_pkg::MAC_W-1:0] val);
        s_valid <= 1'b0;
        // let the predictor take the last accepted byte first
        @(posedge aclk);
        while (rx_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == rfpam_pkg::REG_STATION_MAC) mac_now = val;
    endtask

    task automatic send_frame(input int unsigned len, input dest_kind_t dest, input logic close);
        logic [7:0]  b;
        int unsigned spoil;
        spoil = $urandom_range(rfpam_pkg::MAC_BYTES - 1);
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (i < rfpam_pkg::MAC_BYTES) begin
                case (dest)
                    DEST_BCAST: b = rfpam_pkg::BCAST_BYTE;
                    DEST_OWN:   b = mac_now[8*i +: 8];
                    DEST_NEAR:  b = (i == spoil) ? mac_now[8*i +: 8] ^ (8'h01 << $urandom_range(7))
                                                 : mac_now[8*i +: 8];
                    default:    ;
                endcase
            end
            send_byte(b, close && (i == len - 1));
        end
    endtask

    function automatic void add_row(row_kind_t k, logic idx, logic [rfpam_pkg::MAC_W-1:0] v,
                                    logic fend, logic pinned,
                                    logic [rfpam_pkg::WORD_W-1:0] w,
                                    logic [rfpam_pkg::LEN_W-1:0] l);
        stim_row_t row;
        row = '{k, idx, v, fend, pinned, w, l};
        dir_rows.push_back(row);
    endfunction

    function automatic int unsigned random_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return $urandom_range(1, 6);
        if (r < 60) return $urandom_range(7, 40);
        if (r < 90) return $urandom_range(55, 70);
        return $urandom_range(71, 130);
    endfunction

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 rx_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned random_start;
        int unsigned pick;
        int unsigned boundary_lens[$];
        rx_result_t  pin;

        // Directed rows: kind, reg, value/byte, end, pinned, status word, padded length
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'hab, 1'b1, 1'b0, '0, '0);  // dropped
        add_row(ROW_CFG,  rfpam_pkg::REG_RX_ENABLED,  'h1, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h00, 1'b1, 1'b1,
                HDR_OK | HDR_STATION, PAD_LEN_60);
        add_row(ROW_CFG,  rfpam_pkg::REG_STATION_MAC, 48'hffff_ffff_ffff, 1'b0, 1'b0, '0, '0);
        repeat (5) add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'hff, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'hff, 1'b1, 1'b1,
                HDR_OK | HDR_BCAST | HDR_STATION, PAD_LEN_60);
        add_row(ROW_CFG,  rfpam_pkg::REG_STATION_MAC, 48'h5544_3322_1100, 1'b0, 1'b0, '0, '0);
        for (int i = 0; i < 5; i++) begin
            add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h11 * i, 1'b0, 1'b0, '0, '0);
        end
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h55, 1'b1, 1'b1,
                HDR_OK | HDR_STATION, PAD_LEN_60);
        // short frame: missing address bytes do not match a nonzero station address
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h00, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h11, 1'b1, 1'b1, HDR_OK, PAD_LEN_60);
        // abort a frame by turning reception off, then start over
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h12, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h34, 1'b0, 1'b0, '0, '0);
        add_row(ROW_CFG,  rfpam_pkg::REG_RX_ENABLED,  'h0, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h56, 1'b0, 1'b0, '0, '0);
        add_row(ROW_CFG,  rfpam_pkg::REG_RX_ENABLED,  'h1, 1'b0, 1'b0, '0, '0);
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'h78, 1'b1, 1'b1, HDR_OK, PAD_LEN_60);
        // lone all-ones byte is too short for broadcast
        add_row(ROW_BYTE, rfpam_pkg::REG_STATION_MAC, 'hff, 1'b1, 1'b1, HDR_OK, PAD_LEN_60);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_reg(dir_rows[k].reg_index, dir_rows[k].value);
            end else begin
                if (dir_rows[k].pinned) begin
                    pin = '0;
                    pin.is_status    = 1'b1;
                    pin.last         = 1'b1;
                    pin.status_word  = dir_rows[k].word;
                    pin.frame_length = dir_rows[k].len;
                    pinned_status.push_back(pin);
                end
                send_byte(dir_rows[k].value[7:0], dir_rows[k].frame_end);
            end
        end

        // sizes around the minimum frame
        boundary_lens = {59, 60, 64};
        foreach (boundary_lens[k]) begin
            send_frame(boundary_lens[k], dest_kind_t'($urandom_range(3)), 1'b1);
        end

        random_start = live_items;
        while (live_items - random_start < RANDOM_ITEMS) begin
            steady_run = (live_items - random_start >= STEADY_FROM) &&
                         (live_items - random_start < STEADY_TO);
            pick = $urandom_range(99);
            if (pick < 8) begin
                case ($urandom_range(3))
                    0:       write_reg(rfpam_pkg::REG_STATION_MAC, '0);
                    1:       write_reg(rfpam_pkg::REG_STATION_MAC, '1);
                    default: write_reg(rfpam_pkg::REG_STATION_MAC,
                                       rfpam_pkg::MAC_W'({$urandom, $urandom}));
                endcase
            end else if (pick < 12) begin
                // whole frame while reception is off
                write_reg(rfpam_pkg::REG_RX_ENABLED, 'h0);
                send_frame($urandom_range(1, 12), DEST_ANY, 1'b1);
                write_reg(rfpam_pkg::REG_RX_ENABLED, 'h1);
            end else if (pick < 20) begin
                // broken frame: stop midway, maybe drop a few bytes, resume
                send_frame($urandom_range(1, 10), dest_kind_t'($urandom_range(3)), 1'b0);
                write_reg(rfpam_pkg::REG_RX_ENABLED, 'h0);
                repeat ($urandom_range(2)) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                write_reg(rfpam_pkg::REG_RX_ENABLED, 'h1);
            end else begin
                send_frame(random_len(), dest_kind_t'($urandom_range(3)), 1'b1);
            end
        end
        steady_run = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (rx_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE * 4) @(posedge aclk);

        $display("Sent %0d bytes, %0d taken into frames; checked %0d results over %0d frames",
                 items_in, live_items, results_seen, frames_closed);
        $display("Failures seen: %0d", error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/rfpam_pkg.sv
hdl/rfpam_front.sv
hdl/rfpam_queue.sv
hdl/rfpam_back.sv
hdl/rx_frame_pad_and_address_match_unit.sv
sim/testbench.sv
